// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define FDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define FDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fdp_pkg.sv -----
`default_nettype none

package fdp_pkg;

  // Default depth of the accepted-entry table.
  localparam int unsigned MaxEntriesDef = 64;

  // Marker and attribute codes of a short-name entry.
  localparam logic [7:0] EndMarker   = 8'h00;
  localparam logic [7:0] DelMarker   = 8'hE5;
  localparam logic [7:0] AttrLfn     = 8'h0F;
  localparam int unsigned AttrVolBit = 3;
  localparam int unsigned AttrDirBit = 4;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDot       = 8'h2E;

  typedef enum logic [2:0] {
    KIND_FILE     = 3'd0,
    KIND_DIR      = 3'd1,
    KIND_END      = 3'd2,
    KIND_DELETED  = 3'd3,
    KIND_LONGNAME = 3'd4,
    KIND_VOLUME   = 3'd5,
    KIND_DOT      = 3'd6,
    KIND_SKIPPED  = 3'd7
  } kind_e;

  // Formatted name handed from the formatter to the top level.
  typedef struct packed {
    logic [63:0] head;
    logic [31:0] tail;
    logic [3:0]  len;
    logic        dot_first;
  } name_t;

  // Fold upper-case ASCII letters to lower case.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fdp_name_fmt.sv -----
`default_nettype none

module fdp_name_fmt
  import fdp_pkg::*;
(
  input  logic [63:0] name_base_i,
  input  logic [23:0] name_ext_i,
  output name_t       name_o
);

  logic [7:0] base_b [8];
  logic [7:0] ext_b  [3];
  logic [7:0] txt    [12];
  logic [3:0] blen;
  logic [1:0] elen;
  logic       has_ext;
  logic [3:0] len;

  // Split the raw fields into bytes.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      base_b[i] = name_base_i[8*i +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      ext_b[i] = name_ext_i[8*i +: 8];
    end
  end

  // Find the trimmed base length and the extension length.
  always_comb begin
    blen = '0;
    for (int i = 0; i < 8; i++) begin
      if (base_b[i] != ChSpace) begin
        blen = 4'(i + 1);
      end
    end
    has_ext = (ext_b[0] != ChSpace);
    if (!has_ext) begin
      elen = 2'd0;
    end else if (ext_b[1] == ChSpace) begin
      elen = 2'd1;
    end else if (ext_b[2] == ChSpace) begin
      elen = 2'd2;
    end else begin
      elen = 2'd3;
    end
    len = has_ext ? (blen + 4'd1 + {2'b00, elen}) : blen;
  end

  // Place each output byte: base, then dot, then extension, then zero.
  always_comb begin
    logic [3:0] k;
    for (int p = 0; p < 12; p++) begin
      txt[p] = 8'h00;
      k = 4'(p) - blen;
      if (4'(p) < blen) begin
        txt[p] = to_lower(base_b[p % 8]);
      end else if (has_ext) begin
        case (k)
          4'd0: txt[p] = ChDot;
          4'd1: txt[p] = to_lower(ext_b[0]);
          4'd2: txt[p] = (elen >= 2'd2) ? to_lower(ext_b[1]) : 8'h00;
          4'd3: txt[p] = (elen == 2'd3) ? to_lower(ext_b[2]) : 8'h00;
          default: txt[p] = 8'h00;
        endcase
      end
    end
  end

  // Pack the result.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_o.head[8*i +: 8] = txt[i];
    end
    for (int i = 0; i < 4; i++) begin
      name_o.tail[8*i +: 8] = txt[8 + i];
    end
    name_o.len       = len;
    name_o.dot_first = (len != 4'd0) && (txt[0] == ChDot);
  end

endmodule

`default_nettype wire

// ----- sv/fdp_classify.sv -----
`default_nettype none

module fdp_classify
  import fdp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       first_entry_i,
  input  logic [7:0] first_byte_i,
  input  logic [7:0] attributes_i,
  input  logic       dot_first_i,
  output kind_e      kind_o,
  output logic [5:0] slot_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_cur;
  logic            done_q, done_d, done_cur;
  logic            stopped;

  // Classify the entry and work out the next scan state.
  always_comb begin
    cnt_cur  = first_entry_i ? '0 : cnt_q;
    done_cur = first_entry_i ? 1'b0 : done_q;
    stopped  = done_cur || (cnt_cur >= CntW'(MAX_ENTRIES));
    cnt_d    = cnt_cur;
    done_d   = done_cur;
    slot_o   = '0;
    if (stopped) begin
      kind_o = KIND_SKIPPED;
    end else if (first_byte_i == EndMarker) begin
      kind_o = KIND_END;
      done_d = 1'b1;
    end else if (first_byte_i == DelMarker) begin
      kind_o = KIND_DELETED;
    end else if (attributes_i == AttrLfn) begin
      kind_o = KIND_LONGNAME;
    end else if (attributes_i[AttrVolBit]) begin
      kind_o = KIND_VOLUME;
    end else if (dot_first_i) begin
      kind_o = KIND_DOT;
    end else begin
      kind_o = attributes_i[AttrDirBit] ? KIND_DIR : KIND_FILE;
      slot_o = 6'(cnt_cur);
      cnt_d  = cnt_cur + CntW'(1);
    end
  end

  // Commit the scan state when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fat_directory_entry_parser_core.sv -----
// Channel | Valid      | Stall       | Payload
// --------+------------+-------------+--------------------------------------------
// in      | in_valid_i | in_stall_o  | first_entry_i .. size_bytes_i
// out     | out_valid_o| out_stall_i | entry_kind_o .. text_length_o
//
// One request per cycle while in_stall_o is low; an accepted request goes to the request
// register, then to the result register once that is empty or being drained.
// Name formatting and classification are one combinational pass between them.
// Reset clears both valid flags, the accepted count and the end-of-scan flag.
// A stalled result holds; the input side stalls only when both registers are full
// and the result is stalled.
`default_nettype none

module fat_directory_entry_parser_core
  import fdp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_entry_i,
  input  logic [63:0] name_base_i,
  input  logic [23:0] name_ext_i,
  input  logic [7:0]  attributes_i,
  input  logic [15:0] cluster_high_i,
  input  logic [15:0] cluster_low_i,
  input  logic [31:0] size_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  entry_kind_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] start_cluster_o,
  output logic [31:0] length_bytes_o,
  output logic [63:0] text_head_o,
  output logic [31:0] text_tail_o,
  output logic [3:0]  text_length_o
);

  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free, s1_adv, in_acc;

  logic        first_q;
  logic [63:0] base_q;
  logic [23:0] ext_q;
  logic [7:0]  attr_q;
  logic [31:0] clus_q;
  logic [31:0] size_q;

  name_t       name;
  kind_e       kind;
  logic [5:0]  slot;

  logic [2:0]  kind_q;
  logic [5:0]  slot_q;
  logic [31:0] oclus_q;
  logic [31:0] osize_q;
  logic [63:0] head_q;
  logic [31:0] tail_q;
  logic [3:0]  len_q;

  // Handshake: advance when the result register is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      first_q <= first_entry_i;
      base_q  <= name_base_i;
      ext_q   <= name_ext_i;
      attr_q  <= attributes_i;
      clus_q  <= {cluster_high_i, cluster_low_i};
      size_q  <= size_bytes_i;
    end
  end

  fdp_name_fmt u_name_fmt (
    .name_base_i (base_q),
    .name_ext_i  (ext_q),
    .name_o      (name)
  );

  fdp_classify #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (s1_adv),
    .first_entry_i (first_q),
    .first_byte_i  (base_q[7:0]),
    .attributes_i  (attr_q),
    .dot_first_i   (name.dot_first),
    .kind_o        (kind),
    .slot_o        (slot)
  );

  // Load the result register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      kind_q  <= kind;
      slot_q  <= slot;
      oclus_q <= clus_q;
      osize_q <= size_q;
      head_q  <= name.head;
      tail_q  <= name.tail;
      len_q   <= name.len;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_kind_o    = kind_q;
  assign slot_index_o    = slot_q;
  assign start_cluster_o = oclus_q;
  assign length_bytes_o  = osize_q;
  assign text_head_o     = head_q;
  assign text_tail_o     = tail_q;
  assign text_length_o   = len_q;

endmodule

`default_nettype wire

// ----- sv/fdp_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module fdp_checker
  import fdp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  entry_kind_o,
  input logic [5:0]  slot_index_o,
  input logic [63:0] text_head_o,
  input logic [31:0] text_tail_o,
  input logic [3:0]  text_length_o
);

  // Hold a stalled result.
  `FDP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(entry_kind_o) && $stable(text_head_o),
                   "stalled result changed")

  // Formatted name never exceeds twelve bytes.
  `FDP_ASSERT_NOW(a_len_max, out_valid_o, text_length_o <= 4'd12, "name length above twelve")

  // Only accepted files and directories carry a slot.
  `FDP_ASSERT_NOW(a_slot_zero,
                  out_valid_o && entry_kind_o != KIND_FILE && entry_kind_o != KIND_DIR,
                  slot_index_o == 6'd0, "slot on a rejected entry")

  // An empty name leaves every text byte zero.
  `FDP_ASSERT_NOW(a_empty_name, out_valid_o && text_length_o == 4'd0,
                  text_head_o == 64'd0 && text_tail_o == 32'd0, "bytes beyond name length")

endmodule

bind fat_directory_entry_parser_core fdp_checker u_fdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_kind_o  (entry_kind_o),
  .slot_index_o  (slot_index_o),
  .text_head_o   (text_head_o),
  .text_tail_o   (text_tail_o),
  .text_length_o (text_length_o)
);

`default_nettype wire

// ----- verif/fdp_result_checker.sv -----
module fdp_result_checker
  import fdp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        first_entry_i,
  input  logic [63:0] name_base_i,
  input  logic [23:0] name_ext_i,
  input  logic [7:0]  attributes_i,
  input  logic [15:0] cluster_high_i,
  input  logic [15:0] cluster_low_i,
  input  logic [31:0] size_bytes_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  entry_kind_i,
  input  logic [5:0]  slot_index_i,
  input  logic [31:0] start_cluster_i,
  input  logic [31:0] length_bytes_i,
  input  logic [63:0] text_head_i,
  input  logic [31:0] text_tail_i,
  input  logic [3:0]  text_length_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_owed_o
);

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  slot;
    logic [31:0] cluster;
    logic [31:0] bytes;
    logic [63:0] head;
    logic [31:0] tail;
    logic [3:0]  len;
  } entry_result_t;

  entry_result_t parsed_entries[$];
  int unsigned   accepted_total = 0;
  logic          scan_stopped   = 1'b0;
  int unsigned   mismatches     = 0;
  int unsigned   results_owed   = 0;

  assign mismatch_count_o = mismatches;
  assign results_owed_o   = results_owed;

  // Fold an upper-case letter to lower case, pass everything else.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Print one line for a mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] %s mismatch: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    entry_result_t want;
    logic [7:0]    txt [12];
    logic          ext_open;
    int            i;
    int            blen;
    int            n;
    if (!rst_ni) begin
      accepted_total = 0;
      scan_stopped   = 1'b0;
      parsed_entries.delete();
      results_owed  <= 0;
    end else begin
      // Check a delivered result against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (parsed_entries.size() == 0) begin
          flag_mismatch("unexpected result, kind", 64'(entry_kind_i), 64'd0);
        end else begin
          want = parsed_entries.pop_front();
          if (entry_kind_i !== want.kind) begin
            flag_mismatch("entry_kind", 64'(entry_kind_i), 64'(want.kind));
          end
          if (slot_index_i !== want.slot) begin
            flag_mismatch("slot_index", 64'(slot_index_i), 64'(want.slot));
          end
          if (start_cluster_i !== want.cluster) begin
            flag_mismatch("start_cluster", 64'(start_cluster_i), 64'(want.cluster));
          end
          if (length_bytes_i !== want.bytes) begin
            flag_mismatch("length_bytes", 64'(length_bytes_i), 64'(want.bytes));
          end
          if (text_head_i !== want.head) flag_mismatch("text_head", text_head_i, want.head);
          if (text_tail_i !== want.tail) begin
            flag_mismatch("text_tail", 64'(text_tail_i), 64'(want.tail));
          end
          if (text_length_i !== want.len) begin
            flag_mismatch("text_length", 64'(text_length_i), 64'(want.len));
          end
        end
      end

      // Predict the result of an accepted request.
      if (in_valid_i && !in_stall_i) begin
        if (first_entry_i) begin
          accepted_total = 0;
          scan_stopped   = 1'b0;
        end

        // Build the name: trimmed base, then dot and extension up to its first space.
        for (i = 0; i < 12; i++) txt[i] = 8'h00;
        blen = 0;
        for (i = 0; i < 8; i++) begin
          if (name_base_i[8*i +: 8] != ChSpace) blen = i + 1;
        end
        n = 0;
        for (i = 0; i < blen; i++) begin
          txt[n] = fold_case(name_base_i[8*i +: 8]);
          n++;
        end
        if (name_ext_i[7:0] != ChSpace) begin
          txt[n] = ChDot;
          n++;
          ext_open = 1'b1;
          for (i = 0; i < 3; i++) begin
            if (name_ext_i[8*i +: 8] == ChSpace) ext_open = 1'b0;
            if (ext_open) begin
              txt[n] = fold_case(name_ext_i[8*i +: 8]);
              n++;
            end
          end
        end

        // Classify in priority order and advance the table.
        want.slot = '0;
        if (scan_stopped || accepted_total >= MAX_ENTRIES) begin
          want.kind = KIND_SKIPPED;
        end else if (name_base_i[7:0] == EndMarker) begin
          want.kind    = KIND_END;
          scan_stopped = 1'b1;
        end else if (name_base_i[7:0] == DelMarker) begin
          want.kind = KIND_DELETED;
        end else if (attributes_i == AttrLfn) begin
          want.kind = KIND_LONGNAME;
        end else if (attributes_i[AttrVolBit]) begin
          want.kind = KIND_VOLUME;
        end else if (n > 0 && txt[0] == ChDot) begin
          want.kind = KIND_DOT;
        end else begin
          want.kind = attributes_i[AttrDirBit] ? KIND_DIR : KIND_FILE;
          want.slot = accepted_total[5:0];
          accepted_total++;
        end

        want.cluster = {cluster_high_i, cluster_low_i};
        want.bytes   = size_bytes_i;
        for (i = 0; i < 8; i++) want.head[8*i +: 8] = txt[i];
        for (i = 0; i < 4; i++) want.tail[8*i +: 8] = txt[8 + i];
        want.len = n[3:0];
        parsed_entries.push_back(want);
      end

      results_owed <= parsed_entries.size();
    end
  end

endmodule

// ----- verif/tb_fat_directory_entry_parser_core.sv -----
module tb_fat_directory_entry_parser_core;
  import fdp_pkg::*;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        first_entry_i  = 1'b0;
  logic [63:0] name_base_i    = '0;
  logic [23:0] name_ext_i     = '0;
  logic [7:0]  attributes_i   = '0;
  logic [15:0] cluster_high_i = '0;
  logic [15:0] cluster_low_i  = '0;
  logic [31:0] size_bytes_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  entry_kind_o;
  logic [5:0]  slot_index_o;
  logic [31:0] start_cluster_o;
  logic [31:0] length_bytes_o;
  logic [63:0] text_head_o;
  logic [31:0] text_tail_o;
  logic [3:0]  text_length_o;

  int unsigned mismatch_count;
  int unsigned results_owed;
  logic        quiet_phase = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned live_items  = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  fat_directory_entry_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_entry_i  (first_entry_i),
    .name_base_i    (name_base_i),
    .name_ext_i     (name_ext_i),
    .attributes_i   (attributes_i),
    .cluster_high_i (cluster_high_i),
    .cluster_low_i  (cluster_low_i),
    .size_bytes_i   (size_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_kind_o   (entry_kind_o),
    .slot_index_o   (slot_index_o),
    .start_cluster_o(start_cluster_o),
    .length_bytes_o (length_bytes_o),
    .text_head_o    (text_head_o),
    .text_tail_o    (text_tail_o),
    .text_length_o  (text_length_o)
  );

  fdp_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .first_entry_i   (first_entry_i),
    .name_base_i     (name_base_i),
    .name_ext_i      (name_ext_i),
    .attributes_i    (attributes_i),
    .cluster_high_i  (cluster_high_i),
    .cluster_low_i   (cluster_low_i),
    .size_bytes_i    (size_bytes_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_kind_i    (entry_kind_o),
    .slot_index_i    (slot_index_o),
    .start_cluster_i (start_cluster_o),
    .length_bytes_i  (length_bytes_o),
    .text_head_i     (text_head_o),
    .text_tail_i     (text_tail_o),
    .text_length_i   (text_length_o),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  // Stall the result side: mostly free, short holds, now and then a long one.
  always @(posedge clk_i) begin : result_stall
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || (stall_left == 0 && roll < 65)) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
      stall_left--;
      out_stall_i <= 1'b1;
    end
  end

  // Idle cycles before the next request.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Pack text into a space-padded base field, byte 0 lowest.
  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] r;
    int          i;
    r = {8{ChSpace}};
    for (i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // Pack text into a space-padded extension field.
  function automatic logic [23:0] pack_ext(input string s);
    return 24'(pack_text(s));
  endfunction

  // Pick one name character, case boundaries included.
  function automatic logic [7:0] name_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 8'(8'h41 + $urandom_range(0, 25));
    if (roll < 75) return 8'(8'h30 + $urandom_range(0, 9));
    if (roll < 85) return 8'(8'h61 + $urandom_range(0, 25));
    case ($urandom_range(0, 5))
      0: return 8'h40;
      1: return 8'h5B;
      2: return 8'h60;
      3: return 8'h7B;
      4: return 8'h7E;
      default: return 8'h5F;
    endcase
  endfunction

  // Random name of the given length, padded with spaces.
  function automatic logic [63:0] padded_name(input int unsigned chars);
    logic [63:0] r;
    int unsigned i;
    r = {8{ChSpace}};
    for (i = 0; i < chars; i++) r[8*i +: 8] = name_char();
    return r;
  endfunction

  // Cluster or size value, extremes favored.
  function automatic logic [31:0] wide_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Drive one request after a random gap and hold it until accepted.
  task automatic send_entry(input logic first, input logic [63:0] base,
                            input logic [23:0] ext, input logic [7:0] attr,
                            input logic [31:0] cluster, input logic [31:0] bytes);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_entry_i  <= first;
    name_base_i    <= base;
    name_ext_i     <= ext;
    attributes_i   <= attr;
    cluster_high_i <= cluster[31:16];
    cluster_low_i  <= cluster[15:0];
    size_bytes_i   <= bytes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    live_items++;
  endtask

  // Drop valid and hold the sender until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  // Send one directory scan: mostly well-formed entries, some noise.
  task automatic run_scan(input int unsigned count, input logic allow_end);
    int unsigned k;
    int unsigned roll;
    logic [63:0] base;
    logic [23:0] ext;
    logic [7:0]  attr;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      base = padded_name($urandom_range(1, 8));
      ext  = 24'(padded_name($urandom_range(0, 3)));
      attr = 8'($urandom_range(0, 255)) & 8'hF7;
      if (roll < 45) begin
        // file or directory, by the random attributes
      end else if (roll < 58) begin
        attr = attr | 8'h10;
      end else if (roll < 64) begin
        base[7:0] = DelMarker;
      end else if (roll < 74) begin
        attr = AttrLfn;
      end else if (roll < 77) begin
        attr = attr | 8'h08;
      end else if (roll < 82) begin
        base = (roll < 80) ? pack_text(".") : pack_text("..");
        ext  = pack_ext("");
      end else if (roll < 84 && allow_end) begin
        base[7:0] = EndMarker;
      end else if (roll >= 84) begin
        base = {$urandom, $urandom};
        ext  = 24'($urandom);
        attr = 8'($urandom);
      end
      send_entry(k == 0 || $urandom_range(0, 99) == 0, base, ext, attr,
                 wide_value(), wide_value());
    end
    // Close about half the scans that allow an end marker with one.
    if (allow_end && $urandom_range(0, 1) == 1) begin
      base = padded_name($urandom_range(0, 8));
      base[7:0] = EndMarker;
      send_entry(1'b0, base, 24'(padded_name(3)), 8'($urandom), wide_value(), wide_value());
    end
  endtask

  initial begin : stimulus
    logic [63:0] base;
    int unsigned roll;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: name shapes, every kind, priorities, end and restart.
    send_entry(1'b1, pack_text("README"), pack_ext("TXT"), 8'h20, 32'h0000_0003, 32'd1234);
    send_entry(1'b0, pack_text("DOCS"), pack_ext(""), 8'h10, 32'h0001_0002, 32'd0);
    send_entry(1'b0, pack_text("ABCDEFGH"), pack_ext("XYZ"), 8'h01, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    send_entry(1'b0, pack_text("@[`{az~"), pack_ext("A B"), 8'h00, 32'h0, 32'h0);
    send_entry(1'b0, pack_text("NO EXT"), pack_ext(" XY"), 8'h20, 32'h1234_5678, 32'd7);
    send_entry(1'b0, pack_text(""), pack_ext(""), 8'h00, 32'h0000_0010, 32'd0);
    send_entry(1'b0, pack_text("."), pack_ext(""), 8'h10, 32'h0000_0005, 32'd0);
    send_entry(1'b0, pack_text(".."), pack_ext(""), 8'h10, 32'h0, 32'd0);
    send_entry(1'b0, pack_text(""), pack_ext("TXT"), 8'h20, 32'h0000_0009, 32'd99);
    base = pack_text("XOLDFILE");
    base[7:0] = DelMarker;
    send_entry(1'b0, base, pack_ext("BAK"), 8'h20, 32'h0000_0011, 32'd512);
    send_entry(1'b0, base, pack_ext("BAK"), AttrLfn, 32'h0, 32'd0);
    send_entry(1'b0, 64'h0041_0042_0043_0044, 24'h00FF_FF, AttrLfn, 32'h0, 32'd0);
    send_entry(1'b0, pack_text("MYDISK"), pack_ext(""), 8'h08, 32'h0, 32'd0);
    send_entry(1'b0, pack_text("VOLDIR"), pack_ext("X"), 8'h18, 32'h0, 32'd0);
    send_entry(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    send_entry(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 24'hFF_FFFF, AttrLfn, 32'h0, 32'd0);
    send_entry(1'b0, pack_text("LATE"), pack_ext("DAT"), 8'h20, 32'h0000_0020, 32'd1);
    send_entry(1'b1, pack_text("FRESH"), pack_ext("C"), 8'h20, 32'h0000_0030, 32'd2);
    send_entry(1'b1, 64'h0, 24'h0, 8'h00, 32'h0, 32'd0);
    send_entry(1'b0, pack_text("GONE"), pack_ext("H"), 8'h10, 32'h0000_0040, 32'd3);

    // Pause until every result is back.
    drain_results();

    // Fill the table well past its depth once.
    run_scan(150, 1'b0);

    // Random scans with varying idle shapes.
    while (live_items < 1100) begin
      roll = $urandom_range(0, 99);
      quiet_phase <= (roll < 20);
      if (roll >= 90) run_scan($urandom_range(110, 150), 1'b0);
      else run_scan($urandom_range(3, 40), 1'b1);
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    // Drop valid, wait for the last results, then settle.
    in_valid_i <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[fat_directory_entry_parser_core] OK");
    end else begin
      $display("[fat_directory_entry_parser_core] ERROR");
    end
    $finish;
  end

  // Bound the run.
  initial begin
    #20_000_000;
    $display("[fat_directory_entry_parser_core] ERROR");
    $finish;
  end

endmodule

// ----- fat_directory_entry_parser_core.f -----
+incdir+sv
sv/fdp_pkg.sv
sv/fdp_name_fmt.sv
sv/fdp_classify.sv
sv/fat_directory_entry_parser_core.sv
sv/fdp_checker.sv
verif/fdp_result_checker.sv
verif/tb_fat_directory_entry_parser_core.sv
